FILE: src/ugns_pkg.sv
// Types and constants shared by the uniform grid neighbour search core.
// No dependencies.
`timescale 1ns / 1ps
package ugns_pkg;

  localparam int unsigned CmdW = 2;
  localparam int unsigned IdW = 16;
  localparam int unsigned CoordW = 32;
  localparam int unsigned RadW = 31;

  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_RADIUS = 2'd2,
    CMD_NEIGH = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [IdW-1:0] obj_id;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic [RadW-1:0] radius;
  } cmd_t;

  typedef struct packed {
    logic [IdW-1:0] match_id;
    logic match_valid;
    logic last;
    logic overflowed;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_INS,
    ST_FIND,
    ST_SCAN_RD,
    ST_SCAN_A,
    ST_SCAN_B,
    ST_SCAN_C,
    ST_DONE
  } state_e;

  // Signed floor division job / result between control and divider.
  typedef struct packed {
    logic start;
    logic signed [CoordW:0] num;
    logic [CoordW:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic signed [CoordW:0] quo;
  } div_rsp_t;

endpackage

FILE: src/uniform_grid_neighbour_search_core.sv
// Top level of the uniform grid neighbour search core.
// Depends on ugns_pkg, ugns_front and ugns_back.
`timescale 1ns / 1ps
// Commands enter on start while busy is low and wait in a two-beat queue.
// Insert runs three 33-step floor divisions on the shared divider; neighbour and
// radius queries scan the N stored slots one at a time through the table's read
// port. Every query gives at least one result beat on res_valid_o; beats come
// one per strobe and cannot be held off.
module uniform_grid_neighbour_search_core import ugns_pkg::*; #(
  parameter int unsigned MaxEntities = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t cmd_i,
  input  logic cfg_we_i,
  input  logic [RadW-1:0] cfg_data_i,
  output logic res_valid_o,
  output res_t res_o
);
  logic [RadW-1:0] cell_q;
  logic qv, pop;
  cmd_t qc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cell_q <= RadW'(65536);
    else if (cfg_we_i && cfg_data_i != '0) cell_q <= cfg_data_i;
  end

  ugns_front u_front (.clk_i, .rst_ni, .start, .cmd_i, .busy,
                      .vld_o(qv), .cmd_o(qc), .pop_i(pop));

  ugns_back #(.MaxEntities(MaxEntities), .MaxResults(64)) u_back (
    .clk_i, .rst_ni, .vld_i(qv), .cmd_i(qc), .pop_o(pop), .cell_i(cell_q),
    .res_vld_o(res_valid_o), .res_o
  );
endmodule

FILE: src/ugns_div.sv
// Iterative floor divider, one quotient bit per cycle.
// Depends on ugns_pkg.
`timescale 1ns / 1ps
module ugns_div import ugns_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  localparam int unsigned W = CoordW + 1;

  logic [W-1:0] mag_q, mag_d, quo_q, quo_d, den_q, den_d;
  logic [W:0] rem_q, rem_d;
  logic neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [5:0] cnt_q, cnt_d;
  logic [W:0] trial;
  logic [W-1:0] qn;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    cnt_q <= cnt_d;
  end

  always_comb begin
    mag_d = mag_q;
    quo_d = quo_q;
    den_d = den_q;
    rem_d = rem_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {rem_q[W-1:0], mag_q[W-1]} - {1'b0, den_q};
    if (req_i.start) begin
      neg_d = req_i.num[W-1];
      mag_d = req_i.num[W-1] ? W'(-req_i.num) : W'(req_i.num);
      den_d = req_i.den;
      rem_d = '0;
      quo_d = '0;
      cnt_d = 6'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      mag_d = {mag_q[W-2:0], 1'b0};
      if (!trial[W]) begin
        rem_d = trial;
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-1:0], mag_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Floor for negatives: -(q) minus one when a remainder is left.
  always_comb begin
    qn = -quo_q;
    if (rem_q != '0) qn = qn - W'(1);
    rsp_o.done = done_q;
    rsp_o.quo = neg_q ? qn : quo_q;
  end

endmodule

FILE: src/ugns_front.sv
// Command front end: two-entry queue between the port and the engine.
// Depends on ugns_pkg.
`timescale 1ns / 1ps
module ugns_front import ugns_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  cmd_t cmd_i,
  output logic busy,
  output logic vld_o,
  output cmd_t cmd_o,
  input  logic pop_i
);
  cmd_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push;

  assign busy = cnt_q == 2'd2;
  assign push = start && !busy;
  assign vld_o = cnt_q != 2'd0;
  assign cmd_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end
endmodule

FILE: src/ugns_back.sv
// Engine: entity table memory, insert, and slot-ordered query scan.
// Depends on ugns_pkg and ugns_div.
`timescale 1ns / 1ps
module ugns_back import ugns_pkg::*; #(
  parameter int unsigned MaxEntities = 64,
  parameter int unsigned MaxResults = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic vld_i,
  input  cmd_t cmd_i,
  output logic pop_o,
  input  logic [RadW-1:0] cell_i,
  output logic res_vld_o,
  output res_t res_o
);
  localparam int unsigned AW = (MaxEntities > 1) ? $clog2(MaxEntities) : 1;
  localparam int unsigned CW = $clog2(MaxEntities + 1);
  localparam int unsigned RW = $clog2(MaxResults + 1);
  localparam int unsigned EW = IdW + 6 * CoordW;

  logic [EW-1:0] mem [MaxEntities];
  logic [EW-1:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic wr_en;
  logic [EW-1:0] wr_data;

  state_e st_q, st_d;
  cmd_t c_q, c_d;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic [RW-1:0] n_q, n_d;
  logic drop_q, drop_d;
  logic [1:0] ax_q, ax_d;
  logic signed [CoordW-1:0] k_q [3];
  logic signed [CoordW-1:0] k_d [3];
  logic [CoordW:0] span_q, span_d;
  logic found_q, found_d;
  logic hit_q, hit_d;
  logic [IdW-1:0] hid_q, hid_d;
  logic [63:0] sq_q [3];
  logic [63:0] sq_d [3];
  logic ok_q, ok_d;
  logic [63:0] rsq_q, rsq_d;
  logic rv_q, rv_d;
  res_t ro_q, ro_d;
  res_t hold_q, hold_d;
  div_req_t dreq;
  div_rsp_t drsp;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[AW'(cnt_q)] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  ugns_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic [IdW-1:0] e_id;
  logic signed [CoordW-1:0] e_p [3];
  logic signed [CoordW-1:0] e_c [3];
  logic signed [CoordW-1:0] cpos [3];
  logic signed [CoordW:0] dc [3];
  logic [CoordW:0] ac [3];
  logic [CoordW:0] ap [3];
  logic cell_ok, more;

  always_comb begin
    e_id = rd_q[EW-1 -: IdW];
    for (int a = 0; a < 3; a++) begin
      e_p[a] = rd_q[CoordW*(6-a)-1 -: CoordW];
      e_c[a] = rd_q[CoordW*(3-a)-1 -: CoordW];
    end
    cpos[0] = c_q.pos_x;
    cpos[1] = c_q.pos_y;
    cpos[2] = c_q.pos_z;
    cell_ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      dc[a] = (CoordW+1)'(e_c[a]) - (CoordW+1)'(k_q[a]);
      ac[a] = dc[a][CoordW] ? (CoordW+1)'(-dc[a]) : (CoordW+1)'(dc[a]);
      dc[a] = (CoordW+1)'(e_p[a]) - (CoordW+1)'(cpos[a]);
      ap[a] = dc[a][CoordW] ? (CoordW+1)'(-dc[a]) : (CoordW+1)'(dc[a]);
      if (ac[a] > span_q) cell_ok = 1'b0;
    end
    more = (CW'(idx_q) < cnt_q) && (n_q < RW'(MaxResults));
    rd_addr = AW'(idx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      cnt_q <= '0;
      drop_q <= 1'b0;
      rv_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      drop_q <= drop_d;
      rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
    idx_q <= idx_d;
    n_q <= n_d;
    ax_q <= ax_d;
    k_q <= k_d;
    span_q <= span_d;
    found_q <= found_d;
    hit_q <= hit_d;
    hid_q <= hid_d;
    sq_q <= sq_d;
    ok_q <= ok_d;
    rsq_q <= rsq_d;
    ro_q <= ro_d;
    hold_q <= hold_d;
  end

  assign res_vld_o = rv_q;
  assign res_o = ro_q;

  always_comb begin
    st_d = st_q;
    c_d = c_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    n_d = n_q;
    drop_d = drop_q;
    ax_d = ax_q;
    k_d = k_q;
    span_d = span_q;
    found_d = found_q;
    hit_d = hit_q;
    hid_d = hid_q;
    sq_d = sq_q;
    ok_d = ok_q;
    rsq_d = rsq_q;
    rv_d = 1'b0;
    ro_d = ro_q;
    hold_d = hold_q;
    pop_o = 1'b0;
    wr_en = 1'b0;
    wr_data = {c_q.obj_id, c_q.pos_x, c_q.pos_y, c_q.pos_z, k_q[0], k_q[1], k_q[2]};
    dreq = '0;
    dreq.den = (CoordW+1)'(cell_i);
    dreq.num = (CoordW+1)'(cpos[ax_q]);
    case (st_q)
      ST_IDLE: begin
        if (vld_i) begin
          pop_o = 1'b1;
          c_d = cmd_i;
          idx_d = '0;
          n_d = '0;
          ax_d = '0;
          found_d = 1'b0;
          rsq_d = 64'(cmd_i.radius) * 64'(cmd_i.radius);
          span_d = (CoordW+1)'(1);
          case (cmd_e'(cmd_i.cmd))
            CMD_CLEAR: begin
              cnt_d = '0;
              drop_d = 1'b0;
            end
            CMD_INSERT: begin
              if (cnt_q >= CW'(MaxEntities)) drop_d = 1'b1;
              else st_d = ST_DIV;
            end
            CMD_RADIUS: st_d = ST_DIV;
            CMD_NEIGH: st_d = ST_FIND;
            default: ;
          endcase
          if (cmd_e'(cmd_i.cmd) != CMD_NEIGH) begin
            dreq.start = (cmd_e'(cmd_i.cmd) == CMD_INSERT && cnt_q < CW'(MaxEntities))
                         || cmd_e'(cmd_i.cmd) == CMD_RADIUS;
            dreq.num = (CoordW+1)'(cmd_i.pos_x);
          end
        end
      end
      // Cell keys on x, y, z, then the span ceil(r/cell) for a radius query.
      ST_DIV: begin
        if (drsp.done) begin
          if (ax_q == 2'd3) begin
            span_d = $unsigned(drsp.quo);
            st_d = ST_SCAN_RD;
          end else begin
            k_d[ax_q] = CoordW'(drsp.quo);
            ax_d = ax_q + 2'd1;
            dreq.start = 1'b1;
            if (ax_q == 2'd2) begin
              if (cmd_e'(c_q.cmd) == CMD_INSERT) begin
                dreq.start = 1'b0;
                st_d = ST_INS;
              end else begin
                dreq.num = (CoordW+1)'(c_q.radius) + (CoordW+1)'(cell_i) - (CoordW+1)'(1);
              end
            end else begin
              dreq.num = (CoordW+1)'(cpos[ax_q + 2'd1]);
            end
          end
        end
      end
      ST_INS: begin
        wr_en = 1'b1;
        cnt_d = cnt_q + CW'(1);
        st_d = ST_IDLE;
      end
      // Pass over all slots: latest match of the id gives the centre cell.
      ST_FIND: begin
        if (ax_q == 2'd0) begin
          ax_d = 2'd1;
          idx_d = '0;
        end else if (idx_q < cnt_q || ax_q == 2'd2) begin
          ax_d = 2'd2;
          if (ax_q == 2'd2 && e_id == c_q.obj_id) begin
            found_d = 1'b1;
            k_d[0] = e_c[0];
            k_d[1] = e_c[1];
            k_d[2] = e_c[2];
          end
          if (idx_q < cnt_q) idx_d = idx_q + CW'(1);
          else begin
            idx_d = '0;
            st_d = found_q || (ax_q == 2'd2 && e_id == c_q.obj_id) ? ST_SCAN_RD : ST_DONE;
          end
        end else st_d = ST_DONE;
      end
      ST_SCAN_RD: begin
        if (more) st_d = ST_SCAN_A;
        else st_d = ST_DONE;
      end
      ST_SCAN_A: begin
        hid_d = e_id;
        if (cmd_e'(c_q.cmd) == CMD_NEIGH) begin
          hit_d = cell_ok && e_id != c_q.obj_id;
          st_d = ST_SCAN_C;
        end else begin
          ok_d = cell_ok && ap[0] <= (CoordW+1)'(c_q.radius)
                 && ap[1] <= (CoordW+1)'(c_q.radius) && ap[2] <= (CoordW+1)'(c_q.radius);
          for (int a = 0; a < 3; a++) sq_d[a] = 64'(ap[a][CoordW-1:0]) * 64'(ap[a][CoordW-1:0]);
          st_d = ST_SCAN_B;
        end
      end
      ST_SCAN_B: begin
        hit_d = ok_q && ({2'b0, sq_q[0]} + {2'b0, sq_q[1]} + {2'b0, sq_q[2]} <= {2'b0, rsq_q});
        st_d = ST_SCAN_C;
      end
      // A hit is held back until the next one or the end, so that last can be set on the final one.
      ST_SCAN_C: begin
        if (hit_q) begin
          if (n_q != '0) begin
            rv_d = 1'b1;
            ro_d = hold_q;
          end
          hold_d = '{match_id: hid_q, match_valid: 1'b1, last: 1'b0, overflowed: drop_q};
          n_d = n_q + RW'(1);
        end
        idx_d = idx_q + CW'(1);
        st_d = ST_SCAN_RD;
      end
      ST_DONE: begin
        rv_d = 1'b1;
        if (n_q == '0) ro_d = '{match_id: '0, match_valid: 1'b0, last: 1'b1, overflowed: drop_q};
        else begin
          ro_d = hold_q;
          ro_d.last = 1'b1;
        end
        st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

endmodule

FILE: tb/sv/uniform_grid_neighbour_search_core_tb.sv
// Self-checking testbench for uniform_grid_neighbour_search_core.
// Depends on ugns_pkg and the core RTL. Builds its own entity table to predict
// every match beat and checks each beat against it as it leaves the core.
`timescale 1ns / 1ps
module uniform_grid_neighbour_search_core_tb;
  import ugns_pkg::*;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned MatchLimit = 64;
  localparam int unsigned SettleCycles = 400;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned RandomItems = 240;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd_i = '0;
  logic cfg_we_i = 1'b0;
  logic [RadW-1:0] cfg_data_i = '0;
  logic res_valid_o;
  res_t res_o;

  // Predictor state: a copy of the entity table and the cell size.
  int unsigned grid_cell;
  int unsigned slot_count;
  logic table_dropped;
  logic [IdW-1:0] slot_ident [TableDepth];
  int slot_px [TableDepth];
  int slot_py [TableDepth];
  int slot_pz [TableDepth];
  int slot_cx [TableDepth];
  int slot_cy [TableDepth];
  int slot_cz [TableDepth];

  res_t pending_matches[$];
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  bit idle_bursts = 1'b1;

  uniform_grid_neighbour_search_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int floor_cell(int coord);
    longint quo;
    quo = longint'(coord) / longint'(grid_cell);
    if ((longint'(coord) % longint'(grid_cell)) != 0 && coord < 0) quo = quo - 1;
    return int'(quo);
  endfunction

  function automatic longint unsigned dist_abs(longint a, longint b);
    longint d;
    d = a - b;
    return (d < 0) ? longint'(-d) : d;
  endfunction

  function automatic void push_match(logic [IdW-1:0] ident);
    res_t beat;
    beat.match_id = ident;
    beat.match_valid = 1'b1;
    beat.last = 1'b0;
    beat.overflowed = table_dropped;
    pending_matches = {pending_matches, beat};
  endfunction

  // Close a query: mark its final beat, or give the empty answer.
  function automatic void close_query(int unsigned hits);
    res_t beat;
    if (hits == 0) begin
      beat = '0;
      beat.last = 1'b1;
      beat.overflowed = table_dropped;
      pending_matches = {pending_matches, beat};
    end else begin
      pending_matches[pending_matches.size()-1].last = 1'b1;
    end
  endfunction

  function automatic void predict_matches(cmd_t item);
    longint unsigned span, rad, rsq, ex, ey, ez;
    int kx, ky, kz;
    int unsigned hits;
    bit found;
    hits = 0;
    case (cmd_e'(item.cmd))
      CMD_CLEAR: begin
        slot_count = 0;
        table_dropped = 1'b0;
      end
      CMD_INSERT: begin
        if (slot_count >= TableDepth) begin
          table_dropped = 1'b1;
        end else begin
          slot_ident[slot_count] = item.obj_id;
          slot_px[slot_count] = item.pos_x;
          slot_py[slot_count] = item.pos_y;
          slot_pz[slot_count] = item.pos_z;
          slot_cx[slot_count] = floor_cell(item.pos_x);
          slot_cy[slot_count] = floor_cell(item.pos_y);
          slot_cz[slot_count] = floor_cell(item.pos_z);
          slot_count++;
        end
      end
      CMD_RADIUS: begin
        rad = 64'(item.radius);
        span = (rad + grid_cell - 1) / grid_cell;
        rsq = rad * rad;
        kx = floor_cell(item.pos_x);
        ky = floor_cell(item.pos_y);
        kz = floor_cell(item.pos_z);
        for (int i = 0; i < slot_count && hits < MatchLimit; i++) begin
          if (dist_abs(slot_cx[i], kx) > span || dist_abs(slot_cy[i], ky) > span ||
              dist_abs(slot_cz[i], kz) > span) continue;
          ex = dist_abs(slot_px[i], item.pos_x);
          ey = dist_abs(slot_py[i], item.pos_y);
          ez = dist_abs(slot_pz[i], item.pos_z);
          if (ex > rad || ey > rad || ez > rad) continue;
          // each square is under 2**62, so the 64-bit sum cannot wrap
          if (ex * ex + ey * ey + ez * ez <= rsq) begin
            push_match(slot_ident[i]);
            hits++;
          end
        end
        close_query(hits);
      end
      default: begin
        found = 1'b0;
        kx = 0; ky = 0; kz = 0;
        for (int i = 0; i < slot_count; i++) begin
          if (slot_ident[i] == item.obj_id) begin
            found = 1'b1;
            kx = slot_cx[i]; ky = slot_cy[i]; kz = slot_cz[i];
          end
        end
        if (found) begin
          for (int i = 0; i < slot_count && hits < MatchLimit; i++) begin
            if (slot_ident[i] == item.obj_id) continue;
            if (dist_abs(slot_cx[i], kx) > 1 || dist_abs(slot_cy[i], ky) > 1 ||
                dist_abs(slot_cz[i], kz) > 1) continue;
            push_match(slot_ident[i]);
            hits++;
          end
        end
        close_query(hits);
      end
    endcase
  endfunction

  // Check every match beat against the oldest prediction.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_matches.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %p", res_o);
      end else begin
        want = pending_matches.pop_front();
        if (res_o.match_id !== want.match_id || res_o.match_valid !== want.match_valid ||
            res_o.last !== want.last || res_o.overflowed !== want.overflowed) begin
          mismatches++;
          if (mismatches <= 10) $display("beat mismatch: expected %p, got %p", want, res_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_cmd(cmd_e op, logic [IdW-1:0] ident, int px, int py, int pz,
                          logic [RadW-1:0] rad);
    cmd_t item;
    item.cmd = op;
    item.obj_id = ident;
    item.pos_x = px;
    item.pos_y = py;
    item.pos_z = pz;
    item.radius = rad;
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= item;
    do @(posedge clk_i); while (busy);
    predict_matches(item);
  endtask

  task automatic idle_for(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // Hold off until every predicted beat has left the core.
  task automatic drain_matches();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_matches.size() != 0 || busy) @(negedge clk_i);
  endtask

  task automatic write_cell_size(logic [RadW-1:0] value);
    drain_matches();
    // an insert makes no beat, so let any trailing one finish
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (value != 0) grid_cell = {1'b0, value};
  endtask

  function automatic int near_coord();
    return $urandom_range(0, 8 * 65536) - 4 * 65536;
  endfunction

  function automatic int any_coord();
    return ($urandom_range(0, 3) == 0) ? int'($urandom) : near_coord();
  endfunction

  function automatic logic [RadW-1:0] any_radius();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return RadW'($urandom);
      default: return RadW'($urandom_range(0, 4 * 65536));
    endcase
  endfunction

  function automatic logic [IdW-1:0] known_ident();
    if (slot_count == 0 || $urandom_range(0, 4) == 0) return 16'($urandom);
    return slot_ident[$urandom_range(0, slot_count - 1)];
  endfunction

  task automatic test_basic_commands();
    send_cmd(CMD_RADIUS, 16'h0, 0, 0, 0, '0);
    send_cmd(CMD_NEIGH, 16'h1234, 0, 0, 0, '0);
    send_cmd(CMD_INSERT, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, '1);
    send_cmd(CMD_INSERT, 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, '0);
    send_cmd(CMD_INSERT, 16'h0001, 0, 0, 0, '0);
    send_cmd(CMD_INSERT, 16'h0002, 65536, -65536, 32768, '0);
    send_cmd(CMD_INSERT, 16'h0001, 3 * 65536, 0, 0, '0);
    send_cmd(CMD_RADIUS, 16'h0, 0, 0, 0, {RadW{1'b1}});
    send_cmd(CMD_RADIUS, 16'h0, 0, 0, 0, RadW'(2 * 65536));
    send_cmd(CMD_RADIUS, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, RadW'(65536));
    send_cmd(CMD_NEIGH, 16'h0001, 0, 0, 0, '0);
    send_cmd(CMD_NEIGH, 16'h0002, 0, 0, 0, '0);
    send_cmd(CMD_NEIGH, 16'hFFFF, 0, 0, 0, '0);
    send_cmd(CMD_CLEAR, 16'h0, 0, 0, 0, '0);
    send_cmd(CMD_RADIUS, 16'h0, 0, 0, 0, {RadW{1'b1}});
  endtask

  // Fill past capacity, so the sticky drop flag shows.
  task automatic test_capacity();
    for (int i = 0; i < TableDepth + 3; i++)
      send_cmd(CMD_INSERT, 16'(i + 100), near_coord() / 8, near_coord() / 8, 0, '0);
    send_cmd(CMD_RADIUS, 16'h0, 0, 0, 0, {RadW{1'b1}});
    send_cmd(CMD_NEIGH, 16'd100, 0, 0, 0, '0);
    send_cmd(CMD_CLEAR, 16'h0, 0, 0, 0, '0);
    send_cmd(CMD_NEIGH, 16'd100, 0, 0, 0, '0);
  endtask

  // Insert under one cell size, query under another.
  task automatic test_cell_sizes();
    logic [RadW-1:0] sizes [5];
    sizes = '{31'd1, 31'd0, {RadW{1'b1}}, 31'd16384, 31'd65536};
    foreach (sizes[s]) begin
      write_cell_size(sizes[s]);
      for (int i = 0; i < 6; i++)
        send_cmd(CMD_INSERT, 16'(i), any_coord(), any_coord(), any_coord(), '0);
      write_cell_size(RadW'($urandom_range(1, 4 * 65536)));
      send_cmd(CMD_RADIUS, 16'h0, near_coord(), near_coord(), near_coord(), any_radius());
      send_cmd(CMD_NEIGH, 16'd3, 0, 0, 0, '0);
      send_cmd(CMD_CLEAR, 16'h0, 0, 0, 0, '0);
    end
    write_cell_size(31'd65536);
  endtask

  task automatic test_random_mix();
    int unsigned pick;
    for (int k = 0; k < RandomItems; k++) begin
      if (k == RandomItems / 2) drain_matches();
      idle_bursts = (k < RandomItems - 60);
      if (idle_bursts && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 5));
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_cmd(CMD_CLEAR, 16'($urandom), $urandom, $urandom, $urandom, RadW'($urandom));
      end else if (pick < 50) begin
        send_cmd(CMD_INSERT, ($urandom_range(0, 9) == 0) ? known_ident() : 16'($urandom),
                 any_coord(), any_coord(), any_coord(), RadW'($urandom));
      end else if (pick < 75) begin
        send_cmd(CMD_RADIUS, 16'($urandom), any_coord(), any_coord(), any_coord(),
                 any_radius());
      end else begin
        send_cmd(CMD_NEIGH, known_ident(), $urandom, $urandom, $urandom, RadW'($urandom));
      end
    end
  endtask

  initial begin
    grid_cell = 65536;
    slot_count = 0;
    table_dropped = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_basic_commands();
    test_capacity();
    test_cell_sizes();
    test_random_mix();
    drain_matches();
    repeat (SettleCycles) @(negedge clk_i);
    if (mismatches == 0 && pending_matches.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
